// ===== src/cfr_pkg.sv =====
// ----------------------------------------------------------------------------
// cfr_pkg: shared types and constants of the framed point receiver
// Parser phases, opcodes, message kinds, error codes, statistic selectors
// and the CRC-16/CCITT-FALSE byte update.
// ----------------------------------------------------------------------------
package cfr_pkg;

	// crc constants
	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [15:0] CRC_POLY = 16'h1021;

	// window argument sent after a session reset
	localparam logic [7:0] SEQ_NONE = 8'hFF;

	// parser phases, one-hot
	typedef enum logic [8:0] {
		PH_HUNT    = 9'b000000001,
		PH_MAGIC2  = 9'b000000010,
		PH_SEQ     = 9'b000000100,
		PH_LEN_LO  = 9'b000001000,
		PH_LEN_HI  = 9'b000010000,
		PH_PAYLOAD = 9'b000100000,
		PH_CRC_LO  = 9'b001000000,
		PH_CRC_HI  = 9'b010000000,
		PH_CTL     = 9'b100000000
	} phase_t;

	// input opcodes
	typedef enum logic [1:0] {
		OP_BYTE    = 2'd0,
		OP_POINT   = 2'd1,
		OP_RELEASE = 2'd2,
		OP_STAT    = 2'd3
	} opcode_t;

	// result kinds
	localparam logic [1:0] KIND_HELLO  = 2'd0;
	localparam logic [1:0] KIND_WINDOW = 2'd1;
	localparam logic [1:0] KIND_ERROR  = 2'd2;
	localparam logic [1:0] KIND_REPLY  = 2'd3;

	// error codes
	localparam logic [7:0] ERR_LENGTH = 8'd0;
	localparam logic [7:0] ERR_FULL   = 8'd1;
	localparam logic [7:0] ERR_CRC    = 8'd2;

	// statistic selectors
	localparam int ST_RESYNC   = 0;
	localparam int ST_LENGTH   = 1;
	localparam int ST_OVERFLOW = 2;
	localparam int ST_CRC      = 3;
	localparam int ST_FRAMES   = 4;
	localparam int ST_BYTES    = 5;
	localparam int NUM_STATS   = 6;

	// register indexes of the configuration port
	localparam logic [1:0] REG_MAGIC_FIRST = 2'd0;
	localparam logic [1:0] REG_MAGIC_DATA  = 2'd1;
	localparam logic [1:0] REG_MAGIC_CTL   = 2'd2;
	localparam logic [1:0] REG_RESET_CMD   = 2'd3;

	// result header of one transaction: one or two messages
	typedef struct packed {
		logic       two;
		logic [1:0] kind0;
		logic [7:0] arg0;
		logic [1:0] kind1;
		logic [7:0] arg1;
	} res_hdr_t;

	// crc-16/ccitt-false update by one byte, msb first
	function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {b, 8'h00};
		for (int i = 0; i < 8; i++) begin
			c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
		end
		return c;
	endfunction

endpackage

// ===== src/cfr_out_queue.sv =====
// ----------------------------------------------------------------------------
// cfr_out_queue: result queue
// Small first-in first-out store of finished result entries between the
// processing stage and the output channel.
// ----------------------------------------------------------------------------
module cfr_out_queue #(
	parameter int W     = 8,
	parameter int DEPTH = 4
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       push,
	input  logic [W-1:0]               push_data,
	input  logic                       pop,
	output logic [W-1:0]               head_data,
	output logic                       not_empty,
	output logic [$clog2(DEPTH+1)-1:0] count
);
	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH+1);

	logic [W-1:0]  mem_q [DEPTH];
	logic [PW-1:0] wr_q, rd_q;
	logic [CW-1:0] cnt_q;

	// entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_data;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PW'(DEPTH-1)) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == PW'(DEPTH-1)) ? '0 : rd_q + 1'b1;
			end
			cnt_q <= cnt_q + CW'(push) - CW'(pop);
		end
	end

	assign head_data = mem_q[rd_q];
	assign not_empty = (cnt_q != '0);
	assign count     = cnt_q;

endmodule

// ===== src/crc_framed_point_frame_receiver_top.sv =====
// ----------------------------------------------------------------------------
// crc_framed_point_frame_receiver_top: framed point receiver
// Parses magic/length/CRC framed point data into a ring of frame slots held
// in two byte-wide point memories and answers point and statistic reads.
// ----------------------------------------------------------------------------
//
//  channel | handshake                | payload
//  --------+--------------------------+----------------------------------------
//  in      | in_valid / in_stall      | opcode, rx_byte, item_index
//  out     | out_valid / out_stall    | kind, arg, frame_*, point_*, stat_value,
//          |                          | depth, last_in_run
//  cfg     | cfg_we                   | cfg_index, cfg_data
//
// One transaction is taken per cycle while in_stall is low; parser, ring
// pointers and counters update in the accept cycle, the point memories
// register read data into stage 1, and the finished entry then enters a
// four-entry result queue; the two messages of a transaction go out in turn.
// in_stall rises only when the result queue plus the stage in flight is full.
// Reset clears all control state; point memory contents start undefined.
//
module crc_framed_point_frame_receiver_top #(
	parameter int MAX_POINTS = 256,
	parameter int SLOTS      = 4
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic [1:0]                           opcode,
	input  logic [7:0]                           rx_byte,
	input  logic [7:0]                           item_index,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic [1:0]                           kind,
	output logic [7:0]                           arg,
	output logic                                 frame_available,
	output logic [$clog2(MAX_POINTS+1)-1:0]      frame_points,
	output logic [7:0]                           frame_seq,
	output logic [7:0]                           point_x,
	output logic [7:0]                           point_y,
	output logic [31:0]                          stat_value,
	output logic [$clog2(SLOTS+1)-1:0]           depth,
	output logic                                 last_in_run,
	input  logic                                 cfg_we,
	input  logic [1:0]                           cfg_index,
	input  logic [7:0]                           cfg_data
);
	import cfr_pkg::*;

	localparam int PW     = $clog2(MAX_POINTS+1);
	localparam int CW     = $clog2(SLOTS+1);
	localparam int SW     = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int MDEPTH = SLOTS * MAX_POINTS;
	localparam int AW     = (MDEPTH > 1) ? $clog2(MDEPTH) : 1;
	localparam int QDEPTH = 4;
	localparam int QCW    = $clog2(QDEPTH+1);

	typedef struct packed {
		res_hdr_t      hdr;
		logic          avail;
		logic [PW-1:0] points;
		logic [7:0]    seq;
		logic [7:0]    x;
		logic [7:0]    y;
		logic [31:0]   stat;
		logic [CW-1:0] depth;
	} entry_t;

	// configuration registers
	logic [7:0] magic_first_q, magic_data_q, magic_ctl_q, reset_cmd_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			magic_first_q <= 8'hA5;
			magic_data_q  <= 8'h5A;
			magic_ctl_q   <= 8'h5B;
			reset_cmd_q   <= 8'h01;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_MAGIC_FIRST: magic_first_q <= cfg_data;
				REG_MAGIC_DATA:  magic_data_q  <= cfg_data;
				REG_MAGIC_CTL:   magic_ctl_q   <= cfg_data;
				REG_RESET_CMD:   reset_cmd_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// parser and ring state
	phase_t        phase_q, phase_d;
	logic [7:0]    seq_q, seq_d;
	logic [15:0]   cnt_q, cnt_d;
	logic [15:0]   taken_q, taken_d;
	logic [15:0]   crc_q, crc_d;
	logic [7:0]    rcrc_lo_q, rcrc_lo_d;
	logic          storing_q, storing_d;
	logic [SW-1:0] rd_q, rd_d, wr_q, wr_d;
	logic [CW-1:0] slots_q, slots_d;
	logic [PW-1:0] slot_points_q [SLOTS];
	logic [7:0]    slot_seq_q [SLOTS];
	logic [31:0]   stat_q [NUM_STATS];

	logic          accept;
	opcode_t       op;
	logic          commit, release_ok, clear;
	logic [NUM_STATS-1:0] stat_inc;
	res_hdr_t      hdr;
	logic [1:0]    n_res;
	logic          mem_we;
	logic [AW-1:0] wr_addr, rd_addr;
	logic [15:0]   cnt_full;
	logic [16:0]   taken_inc;
	logic          rd_ok;
	logic [31:0]   stat_sel;

	assign accept = in_valid && !in_stall;
	assign op     = opcode_t'(opcode);

	// next-state logic for one transaction
	always_comb begin
		phase_d    = phase_q;
		seq_d      = seq_q;
		cnt_d      = cnt_q;
		taken_d    = taken_q;
		crc_d      = crc_q;
		rcrc_lo_d  = rcrc_lo_q;
		storing_d  = storing_q;
		commit     = 1'b0;
		release_ok = 1'b0;
		clear      = 1'b0;
		stat_inc   = '0;
		hdr        = '0;
		n_res      = 2'd0;
		mem_we     = 1'b0;
		cnt_full   = {rx_byte, cnt_q[7:0]};
		taken_inc  = {1'b0, taken_q} + 17'd1;
		unique case (op)
			OP_BYTE: begin
				stat_inc[ST_BYTES] = 1'b1;
				unique case (phase_q)
					PH_HUNT: begin
						if (rx_byte == magic_first_q) phase_d = PH_MAGIC2;
					end
					PH_MAGIC2: begin
						if (rx_byte == magic_data_q) phase_d = PH_SEQ;
						else if (rx_byte == magic_ctl_q) phase_d = PH_CTL;
						else begin
							stat_inc[ST_RESYNC] = 1'b1;
							phase_d = (rx_byte == magic_first_q) ? PH_MAGIC2 : PH_HUNT;
						end
					end
					PH_CTL: begin
						if (rx_byte == reset_cmd_q) begin
							clear     = 1'b1;
							storing_d = 1'b0;
							n_res     = 2'd2;
							hdr       = '{two: 1'b1, kind0: KIND_HELLO, arg0: 8'd0,
							              kind1: KIND_WINDOW, arg1: SEQ_NONE};
						end
						phase_d = PH_HUNT;
					end
					PH_SEQ: begin
						seq_d   = rx_byte;
						crc_d   = crc16_byte(CRC_INIT, rx_byte);
						phase_d = PH_LEN_LO;
					end
					PH_LEN_LO: begin
						cnt_d   = {8'd0, rx_byte};
						crc_d   = crc16_byte(crc_q, rx_byte);
						phase_d = PH_LEN_HI;
					end
					PH_LEN_HI: begin
						cnt_d = cnt_full;
						crc_d = crc16_byte(crc_q, rx_byte);
						if (cnt_full[0] || cnt_full > 16'(MAX_POINTS)) begin
							stat_inc[ST_LENGTH] = 1'b1;
							n_res   = 2'd2;
							hdr     = '{two: 1'b1, kind0: KIND_WINDOW, arg0: seq_q,
							            kind1: KIND_ERROR, arg1: ERR_LENGTH};
							phase_d = PH_HUNT;
						end else begin
							if (slots_q < CW'(SLOTS)) begin
								storing_d = 1'b1;
							end else begin
								storing_d = 1'b0;
								stat_inc[ST_OVERFLOW] = 1'b1;
								n_res = 2'd1;
								hdr   = '{two: 1'b0, kind0: KIND_ERROR, arg0: ERR_FULL,
								          kind1: 2'd0, arg1: 8'd0};
							end
							taken_d = '0;
							phase_d = (cnt_full == '0) ? PH_CRC_LO : PH_PAYLOAD;
						end
					end
					PH_PAYLOAD: begin
						crc_d   = crc16_byte(crc_q, rx_byte);
						mem_we  = storing_q;
						taken_d = taken_inc[15:0];
						if (taken_inc >= {cnt_q, 1'b0}) phase_d = PH_CRC_LO;
					end
					PH_CRC_LO: begin
						rcrc_lo_d = rx_byte;
						phase_d   = PH_CRC_HI;
					end
					PH_CRC_HI: begin
						if ({rx_byte, rcrc_lo_q} != crc_q) begin
							stat_inc[ST_CRC] = 1'b1;
							n_res = 2'd1;
							hdr   = '{two: 1'b0, kind0: KIND_ERROR, arg0: ERR_CRC,
							          kind1: 2'd0, arg1: 8'd0};
						end else if (storing_q) begin
							commit = 1'b1;
							stat_inc[ST_FRAMES] = 1'b1;
						end
						storing_d = 1'b0;
						phase_d   = PH_HUNT;
					end
					default: phase_d = PH_HUNT;
				endcase
			end
			OP_RELEASE: begin
				if (slots_q != '0) begin
					release_ok = 1'b1;
					n_res = 2'd1;
					hdr   = '{two: 1'b0, kind0: KIND_WINDOW, arg0: slot_seq_q[rd_q],
					          kind1: 2'd0, arg1: 8'd0};
				end
			end
			OP_POINT, OP_STAT: begin
				n_res = 2'd1;
				hdr   = '{two: 1'b0, kind0: KIND_REPLY, arg0: 8'd0, kind1: 2'd0, arg1: 8'd0};
			end
			default: ;
		endcase
	end

	// ring pointers after this transaction
	always_comb begin
		rd_d    = rd_q;
		wr_d    = wr_q;
		slots_d = slots_q;
		if (clear) begin
			rd_d    = '0;
			wr_d    = '0;
			slots_d = '0;
		end else begin
			if (commit) begin
				wr_d = (wr_q == SW'(SLOTS-1)) ? '0 : wr_q + 1'b1;
			end
			if (release_ok) begin
				rd_d = (rd_q == SW'(SLOTS-1)) ? '0 : rd_q + 1'b1;
			end
			slots_d = slots_q + CW'(commit) - CW'(release_ok);
		end
	end

	// control state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_HUNT;
			seq_q     <= '0;
			cnt_q     <= '0;
			taken_q   <= '0;
			crc_q     <= CRC_INIT;
			rcrc_lo_q <= '0;
			storing_q <= 1'b0;
			rd_q      <= '0;
			wr_q      <= '0;
			slots_q   <= '0;
		end else if (accept) begin
			phase_q   <= phase_d;
			seq_q     <= seq_d;
			cnt_q     <= cnt_d;
			taken_q   <= taken_d;
			crc_q     <= crc_d;
			rcrc_lo_q <= rcrc_lo_d;
			storing_q <= storing_d;
			rd_q      <= rd_d;
			wr_q      <= wr_d;
			slots_q   <= slots_d;
		end
	end

	// statistic counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_STATS; i++) stat_q[i] <= '0;
		end else if (accept) begin
			for (int i = 0; i < NUM_STATS; i++) begin
				if (clear) stat_q[i] <= 32'(stat_inc[i]);
				else       stat_q[i] <= stat_q[i] + 32'(stat_inc[i]);
			end
		end
	end

	// slot descriptors, written on commit
	always_ff @(posedge clk) begin
		if (accept && commit) begin
			slot_points_q[wr_q] <= cnt_q[PW-1:0];
			slot_seq_q[wr_q]    <= seq_q;
		end
	end

	// point memories: x and y bytes, one entry per point of each slot
	logic [7:0] mem_x [MDEPTH];
	logic [7:0] mem_y [MDEPTH];
	logic [7:0] rdx_s1, rdy_s1;

	assign wr_addr = AW'(wr_q) * AW'(MAX_POINTS) + AW'(taken_q[15:1]);
	assign rd_addr = AW'(rd_q) * AW'(MAX_POINTS) + AW'(item_index);

	always_ff @(posedge clk) begin
		if (accept && mem_we && !taken_q[0]) mem_x[wr_addr] <= rx_byte;
		if (accept && op == OP_POINT) rdx_s1 <= mem_x[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (accept && mem_we && taken_q[0]) mem_y[wr_addr] <= rx_byte;
		if (accept && op == OP_POINT) rdy_s1 <= mem_y[rd_addr];
	end

	// read checks on the oldest frame
	assign rd_ok = (op == OP_POINT) && (slots_q != '0)
	             && ({{PW{1'b0}}, item_index} < {8'd0, slot_points_q[rd_q]})
	             && (32'(item_index) < 32'(MAX_POINTS));
	assign stat_sel = (op == OP_STAT && item_index < 8'(NUM_STATS))
	                ? stat_q[item_index[2:0]] : 32'd0;

	// oldest frame after the update, with the slot being committed forwarded
	logic [PW-1:0] old_points;
	logic [7:0]    old_seq;
	always_comb begin
		old_points = slot_points_q[rd_d];
		old_seq    = slot_seq_q[rd_d];
		if (commit && rd_d == wr_q) begin
			old_points = cnt_q[PW-1:0];
			old_seq    = seq_q;
		end
	end

	// stage 1: waits for point memory read data
	logic        valid_s1, rd_ok_s1;
	entry_t      ent_s1;
	entry_t      push_ent, head_ent;
	logic [QCW-1:0] q_count;
	logic        q_not_empty, q_pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept && (n_res != 2'd0);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rd_ok_s1      <= rd_ok;
			ent_s1.hdr    <= hdr;
			ent_s1.avail  <= (slots_d != '0);
			ent_s1.points <= (slots_d != '0) ? old_points : '0;
			ent_s1.seq    <= (slots_d != '0) ? old_seq : 8'd0;
			ent_s1.x      <= 8'd0;
			ent_s1.y      <= 8'd0;
			ent_s1.stat   <= stat_sel;
			ent_s1.depth  <= slots_d;
		end
	end

	always_comb begin
		push_ent   = ent_s1;
		push_ent.x = rd_ok_s1 ? rdx_s1 : 8'd0;
		push_ent.y = rd_ok_s1 ? rdy_s1 : 8'd0;
	end

	assign in_stall = (q_count + QCW'(valid_s1)) >= QCW'(QDEPTH);

	cfr_out_queue #(
		.W     ($bits(entry_t)),
		.DEPTH (QDEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (valid_s1),
		.push_data (push_ent),
		.pop       (q_pop),
		.head_data (head_ent),
		.not_empty (q_not_empty),
		.count     (q_count)
	);

	// output sequencing over one or two messages of the head entry
	logic sub_q;
	logic is_last;

	assign is_last = !head_ent.hdr.two || sub_q;
	assign q_pop   = out_valid && !out_stall && is_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sub_q <= 1'b0;
		end else if (out_valid && !out_stall) begin
			sub_q <= !is_last;
		end
	end

	assign out_valid       = q_not_empty;
	assign kind            = sub_q ? head_ent.hdr.kind1 : head_ent.hdr.kind0;
	assign arg             = sub_q ? head_ent.hdr.arg1 : head_ent.hdr.arg0;
	assign frame_available = head_ent.avail;
	assign frame_points    = head_ent.points;
	assign frame_seq       = head_ent.seq;
	assign point_x         = head_ent.x;
	assign point_y         = head_ent.y;
	assign stat_value      = head_ent.stat;
	assign depth           = head_ent.depth;
	assign last_in_run     = is_last;

	// checks
	a_queue_room: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> (q_count < QCW'(QDEPTH)))
		else $error("result queue overrun");

	a_ring_bound: assert property (@(posedge clk) disable iff (!arst_n)
		slots_q <= CW'(SLOTS))
		else $error("ring count beyond slot total");

	a_storing_phase: assert property (@(posedge clk) disable iff (!arst_n)
		storing_q |-> (phase_q == PH_PAYLOAD || phase_q == PH_CRC_LO || phase_q == PH_CRC_HI))
		else $error("storing outside frame body");

	a_second_msg: assert property (@(posedge clk) disable iff (!arst_n)
		sub_q |-> (q_not_empty && head_ent.hdr.two))
		else $error("second message without a two-message entry");

endmodule
